// File: sv/mlhjs_pkg.sv
// shared types and constants for the multi-lane hash job scheduler
// used by mlhjs_ctrl, mlhjs_dp and the top level

package mlhjs_pkg;

   localparam int LANES_DEF   = 32;
   localparam int STACKS      = 4;
   localparam int STACK_W     = 64;
   localparam int LANE_W      = 5;
   localparam int CNT_W       = 6;
   localparam int TAG_W       = 16;
   localparam int BLK_W       = 24;
   localparam int GROUP_LANES = 8;

   localparam logic FUNC_SUBMIT = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   localparam logic [CNT_W-1:0] MAX_ACTIVE_RST = 6'd32;

   typedef struct packed {
      logic capture;
      logic insert;
      logic rel;
      logic run_clr;
      logic scan_step;
      logic sub;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic rel_found;
      logic run_needed;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// File: sv/multi_lane_hash_job_scheduler.sv
// Job scheduler for a multi-lane hash engine. Each request word (submit or
// flush) gives exactly one response word. A request that needs no run goes
// through insert and release to the response register; one that needs a run
// also passes the minimum scan, which reads one group of eight lanes per
// cycle, then the subtract and a further release. The next request is taken
// while a response still waits; the block only holds back at its last step
// if the earlier response has not been taken. max_active_lanes resets to 32;
// the user must write it over the csr port only while the block is idle, and
// the block itself does not enforce this.
// depends on mlhjs_pkg, mlhjs_ctrl and mlhjs_dp

module multi_lane_hash_job_scheduler import mlhjs_pkg::*; #(
   parameter int LANES = LANES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [TAG_W-1:0]  req_job_tag,
   input  logic [BLK_W-1:0]  req_job_blocks,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_job_done,
   output logic [TAG_W-1:0]  rsp_done_tag,
   output logic [LANE_W-1:0] rsp_done_lane,
   output logic [BLK_W-1:0]  rsp_blocks_run,
   output logic [CNT_W-1:0]  rsp_lanes_run,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_max_active_lanes
);

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   mlhjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mlhjs_dp #(
      .LANES (LANES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_func             (req_func),
      .req_job_tag          (req_job_tag),
      .req_job_blocks       (req_job_blocks),
      .csr_valid            (csr_valid),
      .csr_max_active_lanes (csr_max_active_lanes),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_job_done         (rsp_job_done),
      .rsp_done_tag         (rsp_done_tag),
      .rsp_done_lane        (rsp_done_lane),
      .rsp_blocks_run       (rsp_blocks_run),
      .rsp_lanes_run        (rsp_lanes_run)
   );

endmodule

// File: sv/mlhjs_ctrl.sv
// sequencing state machine for the scheduler
// depends on mlhjs_pkg; drives commands into mlhjs_dp

module mlhjs_ctrl import mlhjs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_REL    = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_SUB    = 3'd4;
   localparam logic [2:0] ST_REL2   = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_REL;
         end
         ST_REL: begin
            cmd.rel     = 1'b1;
            cmd.run_clr = 1'b1;
            if (sts.rel_found) begin
               state_in = ST_OUT;
            end else if (sts.run_needed) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_REL2;
         end
         ST_REL2: begin
            cmd.rel  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/mlhjs_dp.sv
// lane state, free stacks, tag memory, min scan and result register
// depends on mlhjs_pkg; commanded by mlhjs_ctrl

module mlhjs_dp import mlhjs_pkg::*; #(
   parameter int LANES = LANES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        sts,
   input  logic              req_func,
   input  logic [TAG_W-1:0]  req_job_tag,
   input  logic [BLK_W-1:0]  req_job_blocks,
   input  logic              csr_valid,
   input  logic [CNT_W-1:0]  csr_max_active_lanes,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_job_done,
   output logic [TAG_W-1:0]  rsp_done_tag,
   output logic [LANE_W-1:0] rsp_done_lane,
   output logic [BLK_W-1:0]  rsp_blocks_run,
   output logic [CNT_W-1:0]  rsp_lanes_run
);

   localparam int IW      = $clog2(LANES);
   localparam int NGROUPS = (LANES + GROUP_LANES - 1) / GROUP_LANES;
   localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
   localparam int PAD     = (1 << GRP_W) * GROUP_LANES;

   function automatic logic [STACK_W-1:0] stack_init(input int g);
      logic [STACK_W-1:0] v;
      int                 lane;
      v = '0;
      for (int b = 0; b < GROUP_LANES; b++) begin
         lane = g * GROUP_LANES + b;
         v[8*b +: 8] = (lane < LANES) ? 8'(lane) : 8'hff;
      end
      return v;
   endfunction

   // captured request
   logic             func_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [BLK_W-1:0] blocks_ff;

   logic [CNT_W-1:0] max_active_ff;

   // lane state
   logic [BLK_W-1:0]   rem_ff   [LANES];
   logic [BLK_W-1:0]   rem_in   [LANES];
   logic [LANES-1:0]   busy_ff;
   logic [LANES-1:0]   busy_in;
   logic [STACK_W-1:0] stack_ff [STACKS];
   logic [STACK_W-1:0] stack_in [STACKS];
   logic [CNT_W-1:0]   in_use_ff;
   logic [CNT_W-1:0]   in_use_in;

   logic [TAG_W-1:0] tag_mem [LANES];
   logic [TAG_W-1:0] tag_rd_ff;

   // run bookkeeping
   logic [GRP_W-1:0]  grp_ff;
   logic [BLK_W-1:0]  run_min_ff;
   logic [CNT_W-1:0]  run_cnt_ff;
   logic              done_ff;
   logic [IW-1:0]     done_lane_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_done_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic [LANE_W-1:0] rsp_lane_ff;
   logic [BLK_W-1:0]  rsp_blocks_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   // combinational helpers
   logic [LANES-1:0] active;
   logic             free_found;
   logic [IW-1:0]    free_idx;
   logic [1:0]       ins_grp;
   logic [7:0]       stack_top;
   logic             ins_do;
   logic             rel_found;
   logic [IW-1:0]    rel_idx;
   logic [1:0]       rel_grp;
   logic [CNT_W-1:0] limit;
   logic [BLK_W-1:0] rem_pad [PAD];
   logic [PAD-1:0]   act_pad;
   logic [BLK_W-1:0] grp_min;
   logic             grp_any;
   logic [3:0]       grp_cnt;
   logic [GRP_W+2:0] pidx;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         active[i] = busy_ff[i] && (rem_ff[i] != '0);
      end
   end

   // lowest free lane and lowest finished lane
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      rel_found  = 1'b0;
      rel_idx    = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
         if (busy_ff[i] && (rem_ff[i] == '0)) begin
            rel_found = 1'b1;
            rel_idx   = IW'(i);
         end
      end
   end

   assign ins_grp   = 2'(free_idx >> 3);
   assign rel_grp   = 2'(rel_idx >> 3);
   assign stack_top = stack_ff[ins_grp][7:0];
   // stack top must name a real lane that is still free
   assign ins_do    = cmd.insert && (func_ff == FUNC_SUBMIT) && free_found &&
                      (stack_top < 8'(LANES)) && !busy_ff[stack_top[IW-1:0]];

   assign limit = (max_active_ff > CNT_W'(LANES)) ? CNT_W'(LANES) : max_active_ff;

   // one group of eight lanes per scan cycle
   always_comb begin
      for (int p = 0; p < PAD; p++) begin
         if (p < LANES) begin
            rem_pad[p] = rem_ff[p];
            act_pad[p] = active[p];
         end else begin
            rem_pad[p] = '0;
            act_pad[p] = 1'b0;
         end
      end
      grp_min = '0;
      grp_any = 1'b0;
      grp_cnt = '0;
      pidx    = '0;
      for (int b = 0; b < GROUP_LANES; b++) begin
         pidx = {grp_ff, 3'(b)};
         if (act_pad[pidx]) begin
            if (!grp_any || (rem_pad[pidx] < grp_min)) begin
               grp_min = rem_pad[pidx];
            end
            grp_any = 1'b1;
            grp_cnt = grp_cnt + 4'd1;
         end
      end
   end

   // next lane state
   always_comb begin
      rem_in    = rem_ff;
      busy_in   = busy_ff;
      stack_in  = stack_ff;
      in_use_in = in_use_ff;
      if (ins_do) begin
         rem_in[stack_top[IW-1:0]]  = blocks_ff;
         busy_in[stack_top[IW-1:0]] = 1'b1;
         stack_in[ins_grp]          = stack_ff[ins_grp] >> 8;
         in_use_in                  = in_use_ff + 6'd1;
      end
      if (cmd.rel && rel_found) begin
         busy_in[rel_idx]  = 1'b0;
         stack_in[rel_grp] = {stack_ff[rel_grp][STACK_W-9:0], 8'(rel_idx)};
         if (in_use_ff != '0) begin
            in_use_in = in_use_ff - 6'd1;
         end
      end
      if (cmd.sub) begin
         for (int i = 0; i < LANES; i++) begin
            if (active[i]) begin
               rem_in[i] = rem_ff[i] - run_min_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         in_use_ff     <= '0;
         max_active_ff <= MAX_ACTIVE_RST;
         rsp_valid_ff  <= 1'b0;
         for (int g = 0; g < STACKS; g++) begin
            stack_ff[g] <= stack_init(g);
         end
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= '0;
         end
      end else begin
         busy_ff   <= busy_in;
         in_use_ff <= in_use_in;
         stack_ff  <= stack_in;
         rem_ff    <= rem_in;
         if (csr_valid) begin
            max_active_ff <= csr_max_active_lanes;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         tag_ff    <= req_job_tag;
         blocks_ff <= req_job_blocks;
      end
      if (cmd.run_clr) begin
         grp_ff     <= '0;
         run_min_ff <= '0;
         run_cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         grp_ff <= grp_ff + 1'b1;
         if (grp_any && ((run_cnt_ff == '0) || (grp_min < run_min_ff))) begin
            run_min_ff <= grp_min;
         end
         run_cnt_ff <= run_cnt_ff + CNT_W'(grp_cnt);
      end
      if (cmd.rel) begin
         done_ff      <= rel_found;
         done_lane_ff <= rel_idx;
      end
      if (cmd.load_out) begin
         rsp_done_ff   <= done_ff;
         rsp_tag_ff    <= done_ff ? tag_rd_ff : '0;
         rsp_lane_ff   <= done_ff ? LANE_W'(done_lane_ff) : '0;
         rsp_blocks_ff <= run_min_ff;
         rsp_cnt_ff    <= run_cnt_ff;
      end
   end

   // tag store
   always_ff @(posedge clock) begin
      if (ins_do) begin
         tag_mem[stack_top[IW-1:0]] <= tag_ff;
      end
      if (cmd.rel && rel_found) begin
         tag_rd_ff <= tag_mem[rel_idx];
      end
   end

   assign sts.rel_found  = rel_found;
   assign sts.run_needed = (func_ff == FUNC_FLUSH) || (in_use_ff >= limit);
   assign sts.scan_last  = (grp_ff == GRP_W'(NGROUPS - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_job_done   = rsp_done_ff;
   assign rsp_done_tag   = rsp_tag_ff;
   assign rsp_done_lane  = rsp_lane_ff;
   assign rsp_blocks_run = rsp_blocks_ff;
   assign rsp_lanes_run  = rsp_cnt_ff;

endmodule

// File: test/multi_lane_hash_job_scheduler_test.sv
`timescale 1ns / 100ps
// testbench for multi_lane_hash_job_scheduler: random request words, stalls on the
// response side and several lane limits, every response checked against a predictor
// depends on mlhjs_pkg and the multi_lane_hash_job_scheduler rtl

typedef struct {
   bit                            job_done;
   bit [mlhjs_pkg::TAG_W-1:0]     done_tag;
   bit [mlhjs_pkg::LANE_W-1:0]    done_lane;
   bit [mlhjs_pkg::BLK_W-1:0]     blocks_run;
   bit [mlhjs_pkg::CNT_W-1:0]     lanes_run;
} sched_result_type;

class lane_scheduler_board;
   localparam int NUM_LANES = mlhjs_pkg::LANES_DEF;

   bit [mlhjs_pkg::BLK_W-1:0]   remain [32];
   bit                          busy [32];
   bit [mlhjs_pkg::TAG_W-1:0]   tag_of [32];
   bit [mlhjs_pkg::STACK_W-1:0] free_stack [mlhjs_pkg::STACKS];
   int unsigned                 in_use;
   int unsigned                 lane_cap;
   sched_result_type            due_results [$];
   int unsigned                 errors;

   function new();
      for (int g = 0; g < mlhjs_pkg::STACKS; g++)
         for (int b = 0; b < 8; b++)
            free_stack[g][8*b +: 8] = (8*g + b < NUM_LANES) ? 8'(8*g + b) : 8'hff;
      in_use   = 0;
      lane_cap = 32'(mlhjs_pkg::MAX_ACTIVE_RST);
      errors   = 0;
   endfunction

   function int unsigned pending();
      return due_results.size();
   endfunction

   // lowest finished lane goes back on top of its group's stack
   function int release_finished();
      for (int i = 0; i < NUM_LANES; i++)
         if (busy[i] && remain[i] == 0) begin
            free_stack[i/8] = {free_stack[i/8][mlhjs_pkg::STACK_W-9:0], 8'(i)};
            busy[i] = 1'b0;
            if (in_use > 0)
               in_use--;
            return i;
         end
      return -1;
   endfunction

   function void run_active(output bit [mlhjs_pkg::BLK_W-1:0] least,
                            output int unsigned active);
      least  = 0;
      active = 0;
      if (in_use == 0)
         return;
      for (int i = 0; i < NUM_LANES && active < in_use; i++)
         if (busy[i] && remain[i] != 0) begin
            if (active == 0 || remain[i] < least)
               least = remain[i];
            active++;
         end
      if (active == 0)
         return;
      for (int i = 0; i < NUM_LANES; i++)
         if (busy[i] && remain[i] != 0)
            remain[i] = remain[i] - least;
   endfunction

   function void place_job(bit [mlhjs_pkg::TAG_W-1:0] tag, bit [mlhjs_pkg::BLK_W-1:0] blocks);
      int i;
      int g;
      int lane;
      i = 0;
      while (i < NUM_LANES && busy[i])
         i++;
      if (i >= NUM_LANES)
         return;
      g    = i / 8;
      lane = int'(free_stack[g][7:0]);
      if (lane >= NUM_LANES || busy[lane])
         return;
      remain[lane] = blocks;
      tag_of[lane] = tag;
      busy[lane]   = 1'b1;
      free_stack[g] = free_stack[g] >> 8;
      in_use++;
   endfunction

   function void accept_request(bit func, bit [mlhjs_pkg::TAG_W-1:0] tag,
                                bit [mlhjs_pkg::BLK_W-1:0] blocks);
      sched_result_type          r;
      int                        lane;
      bit [mlhjs_pkg::BLK_W-1:0] least;
      int unsigned               active;
      int unsigned               cap;
      cap    = (lane_cap > NUM_LANES) ? NUM_LANES : lane_cap;
      least  = 0;
      active = 0;
      if (func == mlhjs_pkg::FUNC_SUBMIT)
         place_job(tag, blocks);
      lane = release_finished();
      if (lane < 0 && (func == mlhjs_pkg::FUNC_FLUSH || in_use >= cap)) begin
         run_active(least, active);
         lane = release_finished();
      end
      r.job_done   = (lane >= 0);
      r.done_tag   = (lane >= 0) ? tag_of[lane] : '0;
      r.done_lane  = (lane >= 0) ? lane[mlhjs_pkg::LANE_W-1:0] : '0;
      r.blocks_run = least;
      r.lanes_run  = active[mlhjs_pkg::CNT_W-1:0];
      due_results.push_back(r);
   endfunction

   function void compare_field(string name, bit [31:0] want, bit [31:0] got);
      if (want != got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_completion(sched_result_type got);
      sched_result_type want;
      if (due_results.size() == 0) begin
         $display("%0t: unexpected word: done %0d tag %h lane %0d blocks %h lanes %0d",
                  $time, got.job_done, got.done_tag, got.done_lane, got.blocks_run,
                  got.lanes_run);
         errors++;
         return;
      end
      want = due_results.pop_front();
      compare_field("job_done", 32'(want.job_done), 32'(got.job_done));
      compare_field("done_tag", 32'(want.done_tag), 32'(got.done_tag));
      compare_field("done_lane", 32'(want.done_lane), 32'(got.done_lane));
      compare_field("blocks_run", 32'(want.blocks_run), 32'(got.blocks_run));
      compare_field("lanes_run", 32'(want.lanes_run), 32'(got.lanes_run));
   endfunction
endclass

module multi_lane_hash_job_scheduler_test;
   import mlhjs_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 40;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_func;
   logic [TAG_W-1:0]  req_job_tag;
   logic [BLK_W-1:0]  req_job_blocks;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_job_done;
   logic [TAG_W-1:0]  rsp_done_tag;
   logic [LANE_W-1:0] rsp_done_lane;
   logic [BLK_W-1:0]  rsp_blocks_run;
   logic [CNT_W-1:0]  rsp_lanes_run;
   logic              csr_valid;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_max_active_lanes;

   lane_scheduler_board board = new();
   int unsigned         cycle_count = 0;
   int unsigned         stall_style = 0;

   multi_lane_hash_job_scheduler dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_job_tag          (req_job_tag),
      .req_job_blocks       (req_job_blocks),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_job_done         (rsp_job_done),
      .rsp_done_tag         (rsp_done_tag),
      .rsp_done_lane        (rsp_done_lane),
      .rsp_blocks_run       (rsp_blocks_run),
      .rsp_lanes_run        (rsp_lanes_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_active_lanes (csr_max_active_lanes)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: check the word, then pick the stall for the next cycle
   always @(posedge clock) begin
      sched_result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.job_done   = rsp_job_done;
         seen.done_tag   = rsp_done_tag;
         seen.done_lane  = rsp_done_lane;
         seen.blocks_run = rsp_blocks_run;
         seen.lanes_run  = rsp_lanes_run;
         board.check_completion(seen);
      end
      if (cycle_count % 48 == 0)
         stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ((cycle_count % 16) < 9);
      endcase
   end

   task send_word(bit func, bit [TAG_W-1:0] tag, bit [BLK_W-1:0] blocks, int unsigned gap);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_job_tag    <= tag;
      req_job_blocks <= blocks;
      do @(posedge clock); while (req_stall);
      board.accept_request(func, tag, blocks);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // limit changes only once every response is back and the block has settled
   task set_lane_limit(bit [CNT_W-1:0] value);
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_max_active_lanes <= value;
      csr_valid            <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      board.lane_cap = 32'(value);
   endtask

   task pick_job(output bit func, output bit [TAG_W-1:0] tag, output bit [BLK_W-1:0] blocks);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      func = (roll < 8) ? FUNC_FLUSH : FUNC_SUBMIT;
      tag  = TAG_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 15)
         blocks = 0;
      else if (roll < 55)
         blocks = BLK_W'($urandom_range(1, 40));
      else if (roll < 80)
         blocks = BLK_W'($urandom_range(41, 5000));
      else if (roll < 95)
         blocks = BLK_W'($urandom);
      else
         blocks = '1;
   endtask

   initial begin
      bit [CNT_W-1:0]  limits [11];
      bit              func;
      bit [TAG_W-1:0]  tag;
      bit [BLK_W-1:0]  blocks;
      int unsigned     burst_left;
      int unsigned     gap;

      reset                = 1'b1;
      req_valid            = 1'b0;
      req_func             = FUNC_SUBMIT;
      req_job_tag          = '0;
      req_job_blocks       = '0;
      csr_valid            = 1'b0;
      csr_max_active_lanes = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty flush, zero-length job, extremes, equal counts, drain
      send_word(FUNC_FLUSH, 16'h0000, 24'h000000, 0);
      send_word(FUNC_SUBMIT, 16'hffff, 24'h000000, 0);
      send_word(FUNC_SUBMIT, 16'h0000, 24'hffffff, 0);
      send_word(FUNC_SUBMIT, 16'h1234, 24'h000005, 2);
      send_word(FUNC_SUBMIT, 16'habcd, 24'h000005, 0);
      send_word(FUNC_SUBMIT, 16'h5555, 24'haaaaaa, 0);
      send_word(FUNC_SUBMIT, 16'haaaa, 24'h555555, 1);
      send_word(FUNC_FLUSH, 16'hffff, 24'hffffff, 0);
      send_word(FUNC_FLUSH, 16'h0000, 24'h000000, 0);
      send_word(FUNC_FLUSH, 16'h0000, 24'h000000, 3);
      send_word(FUNC_FLUSH, 16'h0000, 24'h000000, 0);
      send_word(FUNC_FLUSH, 16'h0000, 24'h000000, 0);
      send_word(FUNC_FLUSH, 16'h0000, 24'h000000, 0);

      // limit of one: every submit with nothing finished runs at once
      set_lane_limit(6'd1);
      send_word(FUNC_SUBMIT, 16'h0001, 24'h000001, 0);
      send_word(FUNC_SUBMIT, 16'h8000, 24'h800000, 0);
      send_word(FUNC_SUBMIT, 16'h7fff, 24'h7fffff, 0);
      send_word(FUNC_SUBMIT, 16'h00ff, 24'h000000, 0);

      // zero limit behaves as a run on every submit with nothing finished
      set_lane_limit(6'd0);
      send_word(FUNC_SUBMIT, 16'hff00, 24'h000003, 0);
      send_word(FUNC_FLUSH, 16'h0000, 24'h000000, 0);

      limits = '{6'd63, 6'd1, 6'd8, 6'd32, 6'd0, 6'd17, 6'd2, 6'd31, 6'd32, 6'd4, 6'd32};
      limits[9] = CNT_W'($urandom_range(1, 32));
      burst_left = 0;
      foreach (limits[p]) begin
         set_lane_limit(limits[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_job(func, tag, blocks);
            gap = 0;
            if (burst_left == 0) begin
               gap        = $urandom_range(1, 10);
               burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
            send_word(func, tag, blocks, gap);
         end
      end

      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES + 8) @(posedge clock);
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
